// ===== design/cdll_pkg.sv =====
// Shared types and codes for the circular doubly linked list engine.
// Holds the request and response transaction structs and the operation
// and status codes. No dependencies.
package cdll_pkg;

   localparam int POS_W  = 6;
   localparam int DATA_W = 32;

   typedef enum logic [2:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_INS_POS   = 3'd2,
      OP_DEL_FRONT = 3'd3,
      OP_DEL_BACK  = 3'd4,
      OP_DEL_POS   = 3'd5,
      OP_DISPLAY   = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_INV_POS = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef struct packed {
      op_type                    op;
      logic signed [DATA_W-1:0]  value;
      logic [POS_W-1:0]          position;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [DATA_W-1:0]  element;
      logic                      is_last;
   } rsp_type;

endpackage

// ===== design/circular_doubly_linked_list_engine_unit.sv =====
// Circular doubly linked list engine: node pool in one synchronous memory,
// head, count, fill mark and free-list head in registers, a sequencer that walks the links.
// Depends on cdll_pkg for the transaction structs and codes.
//
//   channel   ports                        direction  handshake
//   request   start, busy, req_data        in         start && !busy
//   response  rsp_strobe, rsp_data         out        one-cycle strobe per result
//
// One transaction is worked at a time; busy is high until its last result.
// An insert takes a freed node off the free list if there is one, walks to the
// insertion point, writes the new node, then its predecessor's next link and
// its successor's prev link. A delete walks to the node, relinks its neighbours
// and returns it to the free list. A display reads the head, then each node in
// turn. Rejected requests answer in the cycle after start. The node memory's
// single read port sets the walk to one link per cycle. Reset is synchronous;
// the node memory needs no clearing. Results cannot be stalled.
module circular_doubly_linked_list_engine_unit #(
   parameter int CAPACITY    = 32,
   parameter int VALUE_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  cdll_pkg::req_type req_data,
   output logic              rsp_strobe,
   output cdll_pkg::rsp_type rsp_data
);
   import cdll_pkg::*;

   localparam int IW    = $clog2(CAPACITY);
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CW > POS_W) ? CW : POS_W) + 1;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic [IW-1:0]                 next;
      logic [IW-1:0]                 prev;
   } node_type;

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_POP   = 13'b0000000000010,
      S_POPD  = 13'b0000000000100,
      S_WALK  = 13'b0000000001000,
      S_GOT   = 13'b0000000010000,
      S_WN    = 13'b0000000100000,
      S_WA    = 13'b0000001000000,
      S_WNX   = 13'b0000010000000,
      S_DA    = 13'b0000100000000,
      S_DNX   = 13'b0001000000000,
      S_DFREE = 13'b0010000000000,
      S_DHEAD = 13'b0100000000000,
      S_DISP  = 13'b1000000000000
   } state_type;

   node_type node_mem [CAPACITY];
   node_type rd_ff;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] wr_addr;
   node_type      wr_node;
   logic          we_val, we_next, we_prev;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] left_ff, left_in;
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] free_head_ff, free_head_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [IW-1:0] n_ff, n_in;
   logic [IW-1:0] a_ff, a_in;
   logic [IW-1:0] nx_ff, nx_in;
   logic          first_ff, first_in;
   logic          front_ff, front_in;
   logic          use_prev_ff, use_prev_in;
   logic          del_ff, del_in;
   logic signed [VALUE_WIDTH-1:0] val_ff, val_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   rsp_type       rsp_ff, rsp_in;

   logic [CMP_W-1:0] pos_cmp, cnt_cmp, p_cmp;

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;
   assign pos_cmp    = CMP_W'(req_data.position);
   assign cnt_cmp    = CMP_W'(count_ff);

   // Node memory: one read port with registered data, one masked write port.
   always_ff @(posedge clock) begin
      rd_ff <= node_mem[rd_addr];
      if (we_val) begin
         node_mem[wr_addr].value <= wr_node.value;
      end
      if (we_next) begin
         node_mem[wr_addr].next <= wr_node.next;
      end
      if (we_prev) begin
         node_mem[wr_addr].prev <= wr_node.prev;
      end
   end

   always_comb begin
      unique case (state_ff)
         S_POP:   rd_addr = free_head_ff;
         S_WALK:  rd_addr = first_ff ? head_ff : rd_ff.next;
         S_DISP:  rd_addr = rd_ff.next;
         default: rd_addr = head_ff;
      endcase
   end

   always_comb begin
      wr_addr = n_ff;
      wr_node = '{value: val_ff, next: nx_ff, prev: a_ff};
      we_val  = 1'b0;
      we_next = 1'b0;
      we_prev = 1'b0;
      unique case (state_ff)
         S_WN: begin
            we_val  = 1'b1;
            we_next = 1'b1;
            we_prev = 1'b1;
         end
         S_WA: begin
            wr_addr      = a_ff;
            wr_node.next = n_ff;
            we_next      = 1'b1;
         end
         S_WNX: begin
            wr_addr      = nx_ff;
            wr_node.prev = n_ff;
            we_prev      = 1'b1;
         end
         S_DA: begin
            wr_addr      = a_ff;
            wr_node.next = nx_ff;
            we_next      = 1'b1;
         end
         S_DNX: begin
            wr_addr      = nx_ff;
            wr_node.prev = a_ff;
            we_prev      = 1'b1;
         end
         S_DFREE: begin
            // The removed node joins the free list through its next link.
            wr_node.next = free_head_ff;
            we_next      = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      fill_in       = fill_ff;
      left_in       = left_ff;
      head_in       = head_ff;
      free_head_in  = free_head_ff;
      cur_in        = cur_ff;
      n_in          = n_ff;
      a_in          = a_ff;
      nx_in         = nx_ff;
      first_in      = first_ff;
      front_in      = front_ff;
      use_prev_in   = use_prev_ff;
      del_in        = del_ff;
      val_in        = val_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      p_cmp         = pos_cmp;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               val_in   = VALUE_WIDTH'(req_data.value);
               first_in = 1'b1;
               rsp_in   = '{status: ST_OK, element: '0, is_last: 1'b1};
               unique case (req_data.op)
                  OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
                     if (req_data.op == OP_INS_FRONT) begin
                        p_cmp = CMP_W'(1);
                     end else if (req_data.op == OP_INS_BACK) begin
                        p_cmp = cnt_cmp + CMP_W'(1);
                     end
                     if (p_cmp == '0 || p_cmp > cnt_cmp + CMP_W'(1)) begin
                        rsp_in.status = ST_INV_POS;
                        rsp_strobe_in = 1'b1;
                     end else if (count_ff == CW'(CAPACITY)) begin
                        rsp_in.status = ST_FULL;
                        rsp_strobe_in = 1'b1;
                     end else begin
                        del_in      = 1'b0;
                        front_in    = (p_cmp == CMP_W'(1));
                        use_prev_in = front_in || (p_cmp == cnt_cmp + CMP_W'(1));
                        left_in     = use_prev_in ? CW'(1) : CW'(p_cmp - CMP_W'(1));
                        // Reuse a freed node if any, else take a fresh one.
                        if (fill_ff != count_ff) begin
                           n_in     = free_head_ff;
                           state_in = S_POP;
                        end else begin
                           n_in     = fill_ff[IW-1:0];
                           fill_in  = fill_ff + CW'(1);
                           state_in = (count_ff == '0) ? S_WN : S_WALK;
                        end
                        a_in  = n_in;
                        nx_in = n_in;
                     end
                  end
                  OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
                     if (req_data.op == OP_DEL_FRONT) begin
                        p_cmp = CMP_W'(1);
                     end else if (req_data.op == OP_DEL_BACK) begin
                        p_cmp = cnt_cmp;
                     end
                     if (count_ff == '0) begin
                        rsp_in.status = ST_EMPTY;
                        rsp_strobe_in = 1'b1;
                     end else if (p_cmp == '0 || p_cmp > cnt_cmp) begin
                        rsp_in.status = ST_INV_POS;
                        rsp_strobe_in = 1'b1;
                     end else begin
                        del_in   = 1'b1;
                        front_in = (p_cmp == CMP_W'(1));
                        left_in  = CW'(p_cmp);
                        state_in = S_WALK;
                     end
                  end
                  OP_DISPLAY: begin
                     if (count_ff == '0) begin
                        rsp_in.status = ST_EMPTY;
                        rsp_strobe_in = 1'b1;
                     end else begin
                        left_in  = count_ff;
                        state_in = S_DHEAD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POP: begin
            state_in = S_POPD;
         end
         S_POPD: begin
            free_head_in = rd_ff.next;
            state_in     = (count_ff == '0) ? S_WN : S_WALK;
         end
         S_WALK: begin
            first_in = 1'b0;
            cur_in   = rd_addr;
            left_in  = left_ff - CW'(1);
            if (left_ff == CW'(1)) begin
               state_in = S_GOT;
            end
         end
         S_GOT: begin
            if (del_ff) begin
               n_in     = cur_ff;
               a_in     = rd_ff.prev;
               nx_in    = rd_ff.next;
               state_in = S_DA;
            end else begin
               a_in     = use_prev_ff ? rd_ff.prev : cur_ff;
               nx_in    = use_prev_ff ? cur_ff : rd_ff.next;
               state_in = S_WN;
            end
         end
         S_WN: begin
            state_in = S_WA;
         end
         S_WA: begin
            state_in = S_WNX;
         end
         S_WNX: begin
            count_in      = count_ff + CW'(1);
            head_in       = front_ff ? n_ff : head_ff;
            rsp_in        = '{status: ST_OK, element: '0, is_last: 1'b1};
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         S_DA: begin
            state_in = S_DNX;
         end
         S_DNX: begin
            state_in = S_DFREE;
         end
         S_DFREE: begin
            count_in     = count_ff - CW'(1);
            free_head_in = n_ff;
            if (count_ff == CW'(1)) begin
               head_in = '0;
            end else if (front_ff) begin
               head_in = nx_ff;
            end
            rsp_in        = '{status: ST_OK, element: '0, is_last: 1'b1};
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         S_DHEAD: begin
            state_in = S_DISP;
         end
         S_DISP: begin
            rsp_in        = '{status: ST_OK, element: DATA_W'(rd_ff.value),
                              is_last: (left_ff == CW'(1))};
            rsp_strobe_in = 1'b1;
            left_in       = left_ff - CW'(1);
            if (left_ff == CW'(1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         fill_ff       <= '0;
         head_ff       <= '0;
         free_head_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         fill_ff       <= fill_in;
         head_ff       <= head_in;
         free_head_ff  <= free_head_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff     <= left_in;
      cur_ff      <= cur_in;
      n_ff        <= n_in;
      a_ff        <= a_in;
      nx_ff       <= nx_in;
      first_ff    <= first_in;
      front_ff    <= front_in;
      use_prev_ff <= use_prev_in;
      del_ff      <= del_in;
      val_ff      <= val_in;
      rsp_ff      <= rsp_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("element count exceeds the pool size");

   a_fill_covers_count: assert property (@(posedge clock) disable iff (reset)
      fill_ff >= count_ff)
      else $error("fresh-node mark fell below the element count");

   a_count_only_at_commit: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_WNX && state_ff != S_DFREE) |=> $stable(count_ff))
      else $error("element count changed outside an insert or delete commit");

   a_disp_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DISP) |=> rsp_strobe_ff)
      else $error("display step produced no result");

   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !rsp_ff.is_last) |-> (state_ff == S_DISP))
      else $error("non-final result without a display in progress");

endmodule
